[sv/word_token_classifier_assert.svh]
// ---------------------------------------------------------------------------
// Word token classifier assertion macros
// Concurrent assertion helpers shared by the classifier modules.
// ---------------------------------------------------------------------------
`ifndef WORD_TOKEN_CLASSIFIER_ASSERT_SVH
`define WORD_TOKEN_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define WTC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("word token classifier check failed");
`define WTC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("word token classifier check failed");
`else
`define WTC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WTC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[sv/wtc_pkg.sv]
// ---------------------------------------------------------------------------
// Word token classifier package
// Item types, token classes and the table of fixed strings.
// ---------------------------------------------------------------------------
package wtc_pkg;

  localparam int unsigned OffsetBits   = 16;
  localparam int unsigned LenBits      = 12;
  localparam int unsigned NumFixed     = 32;
  localparam int unsigned FixTextBits  = 128;
  localparam int unsigned FirstType    = 22;
  localparam int unsigned FirstBool    = 26;
  localparam int unsigned FirstSymbol  = 28;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    ClsKeyword = 3'd0,
    ClsType    = 3'd1,
    ClsSymbol  = 3'd2,
    ClsIdent   = 3'd3,
    ClsInt     = 3'd4,
    ClsString  = 3'd5,
    ClsBool    = 3'd6,
    ClsEof     = 3'd7
  } token_class_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    token_class_e          token_class;
    logic [OffsetBits-1:0] start_offset;
    logic [LenBits-1:0]    token_length;
    logic                  is_last_token;
  } out_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  localparam logic [4:0] FixLen [NumFixed] = '{
    5'd15, 5'd9, 5'd14, 5'd12, 5'd7, 5'd2, 5'd14, 5'd3, 5'd2, 5'd2, 5'd4,
    5'd4, 5'd6, 5'd5, 5'd2, 5'd9, 5'd6, 5'd4, 5'd11, 5'd15, 5'd4, 5'd5,
    5'd7, 5'd7, 5'd6, 5'd4, 5'd4, 5'd5,
    5'd1, 5'd1, 5'd1, 5'd1
  };

  // Strings are right-aligned: the last character sits in the low byte.
  localparam logic [FixTextBits-1:0] FixText [NumFixed] = '{
    {"DEFINE_", "FUNCTION"}, "RETURNING", {"BEGIN_", "FUNCTION"}, {"END_", "FUNCTION"},
    "DECLARE", "AS", {"INITIALIZED", "_TO"}, "SET", "TO", "IF", "THEN", "ELSE",
    "END_IF", "WHILE", "DO", {"END_", "WHILE"}, "RETURN", "CALL", {"IS_EQUAL", "_TO"},
    {"IS_NOT_EQUAL", "_TO"}, "PLUS", "MINUS",
    "INTEGER", "BOOLEAN", "STRING", "VOID",
    "TRUE", "FALSE",
    "(", ")", ";", ","
  };

  function automatic logic [7:0] fix_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [4:0] k;
    logic [7:0] r;
    k = FixLen[idx] - 5'd1 - {1'b0, pos};
    r = FixText[idx][{k[3:0], 3'b000} +: 8];
    return r;
  endfunction

endpackage

[sv/wtc_scanner.sv]
// ---------------------------------------------------------------------------
// Word token classifier scanner
// Word state, live match mask and token classification for one byte a cycle while the queue has room.
// ---------------------------------------------------------------------------
`include "word_token_classifier_assert.svh"

module wtc_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  wtc_pkg::in_item_t  item_i,
  input  logic               room_i,
  output logic               advance_o,
  output wtc_pkg::push_t     push_o,
  output wtc_pkg::out_item_t slot0_o,
  output wtc_pkg::out_item_t slot1_o
);

  logic [wtc_pkg::NumFixed-1:0]   mask_q, mask_d, base_mask, hit, keep;
  logic [wtc_pkg::LenBits-1:0]    len_q, len_d, base_len;
  logic [7:0]                     first_q, first_d, second_q, second_d;
  logic                           in_word_q, in_word_d;
  logic [wtc_pkg::OffsetBits-1:0] pos_q, pos_d, start_q, start_d;
  logic                           delim, emit_word, first_digit, second_digit;
  wtc_pkg::token_class_e          word_class;
  wtc_pkg::out_item_t             word_tok, eof_tok;

  assign advance_o = item_valid_i && room_i;

  assign delim = (item_i.ch == wtc_pkg::ChSpace) || (item_i.ch == wtc_pkg::ChTab) ||
                 (item_i.ch == wtc_pkg::ChLf) || (item_i.ch == wtc_pkg::ChCr);

  assign base_mask = in_word_q ? mask_q : '1;
  assign base_len  = in_word_q ? len_q : '0;

  for (genvar i = 0; i < wtc_pkg::NumFixed; i++) begin : g_fixed
    assign hit[i]  = mask_q[i] && (len_q == wtc_pkg::LenBits'(wtc_pkg::FixLen[i]));
    assign keep[i] = (base_len < wtc_pkg::LenBits'(wtc_pkg::FixLen[i])) &&
                     (wtc_pkg::fix_char(5'(i), base_len[3:0]) == item_i.ch);
  end

  assign first_digit  = (first_q >= wtc_pkg::ChZero) && (first_q <= wtc_pkg::ChNine);
  assign second_digit = (second_q >= wtc_pkg::ChZero) && (second_q <= wtc_pkg::ChNine);

  always_comb begin
    if (|hit[wtc_pkg::FirstType-1:0]) begin
      word_class = wtc_pkg::ClsKeyword;
    end else if (|hit[wtc_pkg::FirstBool-1:wtc_pkg::FirstType]) begin
      word_class = wtc_pkg::ClsType;
    end else if (|hit[wtc_pkg::FirstSymbol-1:wtc_pkg::FirstBool]) begin
      word_class = wtc_pkg::ClsBool;
    end else if (|hit[wtc_pkg::NumFixed-1:wtc_pkg::FirstSymbol]) begin
      word_class = wtc_pkg::ClsSymbol;
    end else if (first_digit || (first_q == wtc_pkg::ChMinus && second_digit)) begin
      word_class = wtc_pkg::ClsInt;
    end else if (first_q == wtc_pkg::ChQuote) begin
      word_class = wtc_pkg::ClsString;
    end else begin
      word_class = wtc_pkg::ClsIdent;
    end
  end

  always_comb begin
    word_tok.token_class   = word_class;
    word_tok.start_offset  = start_q;
    word_tok.token_length  = len_q;
    word_tok.is_last_token = 1'b0;
    eof_tok.token_class    = wtc_pkg::ClsEof;
    eof_tok.start_offset   = pos_q;
    eof_tok.token_length   = '0;
    eof_tok.is_last_token  = 1'b1;
  end

  assign emit_word     = in_word_q && (item_i.is_end || delim);
  assign push_o.first  = advance_o && (emit_word || item_i.is_end);
  assign push_o.second = advance_o && emit_word && item_i.is_end;
  assign slot0_o       = emit_word ? word_tok : eof_tok;
  assign slot1_o       = eof_tok;

  always_comb begin
    mask_d    = mask_q;
    len_d     = len_q;
    first_d   = first_q;
    second_d  = second_q;
    in_word_d = in_word_q;
    pos_d     = pos_q;
    start_d   = start_q;
    if (advance_o) begin
      if (item_i.is_end) begin
        mask_d    = '1;
        len_d     = '0;
        first_d   = '0;
        second_d  = '0;
        in_word_d = 1'b0;
        pos_d     = '0;
        start_d   = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (delim) begin
          in_word_d = 1'b0;
        end else begin
          in_word_d = 1'b1;
          start_d   = in_word_q ? start_q : pos_q;
          first_d   = in_word_q ? first_q : item_i.ch;
          if (base_len == wtc_pkg::LenBits'(1)) begin
            second_d = item_i.ch;
          end else begin
            second_d = in_word_q ? second_q : 8'h00;
          end
          mask_d = base_mask & keep;
          len_d  = (&base_len) ? base_len : base_len + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '1;
      len_q     <= '0;
      first_q   <= '0;
      second_q  <= '0;
      in_word_q <= 1'b0;
      pos_q     <= '0;
      start_q   <= '0;
    end else begin
      mask_q    <= mask_d;
      len_q     <= len_d;
      first_q   <= first_d;
      second_q  <= second_d;
      in_word_q <= in_word_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
    end
  end

  `WTC_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni, advance_o && item_i.is_end, !in_word_q && pos_q == '0)
  `WTC_ASSERT_IMP(a_word_not_empty, clk_i, rst_ni, in_word_q, len_q != '0)
  `WTC_ASSERT_IMP(a_second_after_first, clk_i, rst_ni, push_o.second, push_o.first && room_i)

endmodule

[sv/wtc_queue.sv]
// ---------------------------------------------------------------------------
// Word token classifier result queue
// Small queue taking up to two tokens a cycle and handing out one while not stalled.
// ---------------------------------------------------------------------------
`include "word_token_classifier_assert.svh"

module wtc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wtc_pkg::push_t     push_i,
  input  wtc_pkg::out_item_t slot0_i,
  input  wtc_pkg::out_item_t slot1_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wtc_pkg::out_item_t out_item_o
);

  wtc_pkg::out_item_t               mem_q [wtc_pkg::QueueDepth];
  logic [wtc_pkg::QueuePtrBits-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [wtc_pkg::QueueCntBits-1:0] count_q, count_d, push_n;
  logic                             pop;

  assign push_n      = wtc_pkg::QueueCntBits'(push_i.first) +
                       wtc_pkg::QueueCntBits'(push_i.second);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_item_o  = mem_q[rp_q];
  assign room_o      = count_q <= wtc_pkg::QueueCntBits'(wtc_pkg::QueueDepth - 2);

  assign count_d = count_q + push_n - wtc_pkg::QueueCntBits'(pop);
  assign wp_d    = wp_q + push_n[wtc_pkg::QueuePtrBits-1:0];
  assign rp_d    = rp_q + wtc_pkg::QueuePtrBits'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wp_q] <= slot0_i;
    end
    if (push_i.second) begin
      mem_q[wp_q + 1'b1] <= slot1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  `WTC_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= wtc_pkg::QueueCntBits'(wtc_pkg::QueueDepth))
  `WTC_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, push_i.first, room_o)
  `WTC_ASSERT_NEXT(a_pop_only, clk_i, rst_ni, pop && !push_i.first, count_q == $past(count_q) - 1'b1)

endmodule

[sv/word_token_classifier.sv]
// ---------------------------------------------------------------------------
// Word token classifier
// Splits a byte stream into words and emits one classified token per word.
//
//   Channel | Direction | Handshake               | Item
//   in      | input     | in_valid_i, in_stall_o  | wtc_pkg::in_item_t
//   out     | output    | out_valid_o, out_stall_i| wtc_pkg::out_item_t
//
// One input item is taken every cycle unless the input stalls. Each item is
// registered, and its tokens go into a four-entry queue that hands out one
// token a cycle while out_stall_i is low. Each end-of-source item adds an end
// token, pushed with the token of any word it closes. The input stalls only
// while the queue has fewer than two free entries. Reset clears all word state.
// ---------------------------------------------------------------------------
module word_token_classifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wtc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wtc_pkg::out_item_t out_item_o
);

  logic               in_valid_q, in_valid_d, advance, room;
  wtc_pkg::in_item_t  in_item_q;
  wtc_pkg::push_t     push;
  wtc_pkg::out_item_t slot0, slot1;

  assign in_stall_o = in_valid_q && !advance;
  assign in_valid_d = in_stall_o ? 1'b1 : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  wtc_scanner u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_item_q),
    .room_i       (room),
    .advance_o    (advance),
    .push_o       (push),
    .slot0_o      (slot0),
    .slot1_o      (slot1)
  );

  wtc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .slot0_i     (slot0),
    .slot1_i     (slot1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Word token classifier testbench
// Streams source bytes and end markers into the classifier and predicts each
// token in the bench itself. The driver and the monitor insert random gaps
// and stalls, and every accepted token is compared field by field.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int NumWords      = 32;
  localparam int TailItems     = 60;
  localparam int DrainCycles   = 16;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 320;

  localparam logic [7:0] KeySpace = 8'h20;
  localparam logic [7:0] KeyTab   = 8'h09;
  localparam logic [7:0] KeyLf    = 8'h0a;
  localparam logic [7:0] KeyCr    = 8'h0d;
  localparam logic [7:0] KeyMinus = 8'h2d;
  localparam logic [7:0] KeyQuote = 8'h22;
  localparam logic [7:0] Separators [4] = '{KeySpace, KeyTab, KeyLf, KeyCr};

  string fixed_words [NumWords] = '{
    string'({"DEFINE_", "FUNCTION"}), "RETURNING", string'({"BEGIN_", "FUNCTION"}),
    string'({"END_", "FUNCTION"}), "DECLARE", "AS", string'({"INITIALIZED", "_TO"}),
    "SET", "TO", "IF", "THEN", "ELSE", "END_IF", "WHILE", "DO",
    string'({"END_", "WHILE"}), "RETURN", "CALL", string'({"IS_EQUAL", "_TO"}),
    string'({"IS_NOT_EQUAL", "_TO"}), "PLUS", "MINUS",
    "INTEGER", "BOOLEAN", "STRING", "VOID",
    "TRUE", "FALSE",
    "(", ")", ";", ","
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  wtc_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  wtc_pkg::out_item_t out_item_o;

  wtc_pkg::in_item_t  source_queue [$];
  wtc_pkg::out_item_t expected_tokens [$];

  // Scanner state mirrored by the bench.
  logic [31:0] live_mask;
  logic [11:0] run_len;
  logic [7:0]  lead_ch;
  logic [7:0]  next_ch;
  logic        word_open;
  logic [15:0] src_pos;
  logic [15:0] word_base;

  int mismatch_count = 0;
  int items_sent     = 0;
  int end_markers    = 0;
  int tokens_checked = 0;
  int class_tally [8] = '{default: 0};
  int send_gap       = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  word_token_classifier uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic is_separator(input logic [7:0] c);
    return c == KeySpace || c == KeyTab || c == KeyLf || c == KeyCr;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] rand_word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_separator(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(65, 90));
  endfunction

  task automatic clear_scanner();
    live_mask = '1;
    run_len   = '0;
    lead_ch   = '0;
    next_ch   = '0;
    word_open = 1'b0;
    src_pos   = '0;
    word_base = '0;
  endtask

  function automatic wtc_pkg::token_class_e word_class();
    for (int i = 0; i < NumWords; i++) begin
      if (live_mask[i] && run_len == 12'(fixed_words[i].len())) begin
        if (i < 22) return wtc_pkg::ClsKeyword;
        if (i < 26) return wtc_pkg::ClsType;
        if (i < 28) return wtc_pkg::ClsBool;
        return wtc_pkg::ClsSymbol;
      end
    end
    if (is_numeral(lead_ch) || (lead_ch == KeyMinus && is_numeral(next_ch)))
      return wtc_pkg::ClsInt;
    if (lead_ch == KeyQuote) return wtc_pkg::ClsString;
    return wtc_pkg::ClsIdent;
  endfunction

  task automatic queue_token(input wtc_pkg::token_class_e cls, input logic [15:0] offset,
                             input logic [11:0] len, input logic last);
    wtc_pkg::out_item_t tok;
    tok.token_class   = cls;
    tok.start_offset  = offset;
    tok.token_length  = len;
    tok.is_last_token = last;
    expected_tokens.push_back(tok);
  endtask

  task automatic absorb_source_item(input wtc_pkg::in_item_t it);
    logic [7:0] c;
    c = it.ch;
    if (it.is_end) begin
      if (word_open) queue_token(word_class(), word_base, run_len, 1'b0);
      queue_token(wtc_pkg::ClsEof, src_pos, '0, 1'b1);
      clear_scanner();
    end else begin
      if (is_separator(c)) begin
        if (word_open) begin
          queue_token(word_class(), word_base, run_len, 1'b0);
          word_open = 1'b0;
        end
      end else begin
        if (!word_open) begin
          word_open = 1'b1;
          word_base = src_pos;
          run_len   = '0;
          live_mask = '1;
          lead_ch   = c;
          next_ch   = '0;
        end
        if (run_len == 12'd1) next_ch = c;
        for (int i = 0; i < NumWords; i++) begin
          if (!(int'(run_len) < fixed_words[i].len() &&
                8'(fixed_words[i][int'(run_len)]) == c))
            live_mask[i] = 1'b0;
        end
        if (run_len != '1) run_len = run_len + 12'd1;
      end
      src_pos = src_pos + 16'd1;
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    wtc_pkg::in_item_t it;
    it.ch     = b;
    it.is_end = 1'b0;
    source_queue.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int j = 0; j < s.len(); j++) put_byte(8'(s[j]));
  endtask

  task automatic put_end();
    wtc_pkg::in_item_t it;
    it.ch     = 8'($urandom_range(0, 255));
    it.is_end = 1'b1;
    source_queue.push_back(it);
  endtask

  task automatic put_gap();
    repeat ($urandom_range(1, 2)) put_byte(Separators[$urandom_range(0, 3)]);
  endtask

  task automatic put_random_word();
    string w;
    int    n;
    int    hit;
    w = fixed_words[$urandom_range(0, NumWords - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: put_text(w);
      3: begin
        hit = $urandom_range(0, w.len() - 1);
        case ($urandom_range(0, 2))
          0: for (int j = 0; j < w.len() - 1; j++) put_byte(8'(w[j]));
          1: begin
            put_text(w);
            put_byte(rand_letter());
          end
          default: for (int j = 0; j < w.len(); j++)
            put_byte(j == hit ? rand_letter() : 8'(w[j]));
        endcase
        if (w.len() == 1 && hit == 0) put_byte(rand_letter());
      end
      4: begin
        if ($urandom_range(0, 2) == 0) put_byte(KeyMinus);
        n = $urandom_range(1, 5);
        repeat (n) put_byte(8'($urandom_range(48, 57)));
      end
      5: begin
        put_byte(KeyQuote);
        repeat ($urandom_range(0, 6)) put_byte(rand_word_byte());
      end
      6: repeat ($urandom_range(1, 10))
        put_byte(rand_letter() | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      7: repeat ($urandom_range(1, 5)) put_byte(rand_word_byte());
      8: begin
        put_byte(KeyMinus);
        if ($urandom_range(0, 1)) put_byte(rand_letter());
      end
      default: repeat ($urandom_range(16, 40)) put_byte(rand_word_byte());
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: presents the oldest pending item and holds it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      send_gap = 0;
      clear_scanner();
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        absorb_source_item(in_item_i);
        void'(source_queue.pop_front());
        items_sent++;
        if (in_item_i.is_end) end_markers++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (source_queue.size() > TailItems && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= source_queue.size() != 0;
        if (source_queue.size() != 0) in_item_i <= source_queue[0];
      end
    end
  end

  // Monitor: stalls the token channel in bursts and checks each token taken.
  always @(posedge clk_i or negedge rst_ni) begin
    wtc_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t ns: token with none expected, expected none, actual class %0d offset %0d",
                   $time, out_item_o.token_class, out_item_o.start_offset);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_class", want.token_class, out_item_o.token_class);
          check_field("start_offset", want.start_offset, out_item_o.start_offset);
          check_field("token_length", want.token_length, out_item_o.token_length);
          check_field("is_last_token", want.is_last_token, out_item_o.is_last_token);
          class_tally[want.token_class]++;
          tokens_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (source_queue.size() > TailItems && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, WatchdogLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    string directed_words [] = '{
      string'({"DEFINE_", "FUNCTION"}), "x", "INTEGER", "TRUE", "FALSE", "(", ",",
      string'({"IS_NOT_EQUAL", "_TO"}), "IS_EQUAL_TOX", "DEFIN", "42", "-7", "-", "-a",
      "\"hi", "STRING", string'({"END_", "WHILE"}), "0", "9z"
    };
    int target;

    // Empty source, then leading separators and every separator kind.
    put_end();
    put_byte(KeySpace);
    put_byte(KeyCr);
    foreach (directed_words[i]) begin
      put_text(directed_words[i]);
      put_byte(Separators[i % 4]);
    end
    put_byte(8'h00);
    put_byte(KeyCr);
    put_byte(8'hff);
    put_byte(KeyTab);
    put_text("BOOLEAN");
    put_end();
    put_text("VOID");
    put_byte(KeySpace);
    put_end();
    put_text("RETURN");
    put_byte(KeyLf);

    target = source_queue.size() + RandomItems;
    while (source_queue.size() < target) begin
      put_random_word();
      if ($urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1)) put_gap();
        put_end();
      end else begin
        put_gap();
      end
    end
    put_end();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (source_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d source items with %0d end markers; %0d tokens checked.",
             items_sent, end_markers, tokens_checked);
    $display("Classes: kw %0d type %0d sym %0d id %0d int %0d str %0d bool %0d eof %0d",
             class_tally[wtc_pkg::ClsKeyword], class_tally[wtc_pkg::ClsType],
             class_tally[wtc_pkg::ClsSymbol], class_tally[wtc_pkg::ClsIdent],
             class_tally[wtc_pkg::ClsInt], class_tally[wtc_pkg::ClsString],
             class_tally[wtc_pkg::ClsBool], class_tally[wtc_pkg::ClsEof]);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
